// File: rtl/assert_macros.svh
// Assertion macros used by the spill slot allocator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/ssa_pkg.sv
// Types, codes and defaults of the spill slot allocator
`default_nettype none

package ssa_pkg;

  localparam int DEFAULT_SLOTS      = 64;
  localparam int DEFAULT_SLOT_BYTES = 8;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int BASE_W = 16;
  // holds slot + base + 1 and signed range limits for slots up to 1023
  localparam int CALC_W = 18;

  localparam logic [1:0] OP_REUSE     = 2'd0;
  localparam logic [1:0] OP_PERMANENT = 2'd1;
  localparam logic [1:0] OP_RELEASE   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNCHANGED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [1:0] REG_GPR_BASE = 2'd0;
  localparam logic [1:0] REG_XMM_BASE = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;

  localparam logic [BASE_W-1:0] GPR_BASE_RESET = 16'd256;
  localparam logic [BASE_W-1:0] XMM_BASE_RESET = 16'd16384;
  localparam logic [BASE_W-1:0] LIMIT_RESET    = 16'd32768;

  typedef struct packed {
    logic [1:0]  op;
    logic        reg_class;
    logic        has_slot;
    logic [5:0]  slot_index;
    logic [31:0] interval_start;
    logic [31:0] interval_end;
  } req_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               fresh;
    logic signed [31:0] frame_offset;
    logic [1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/spill_slot_allocator_top.sv
// Spill slot allocator: first-fit interval slot tables for two register classes
`default_nettype none

// Keeps one slot table per register class in a memory with one read and one
// write port and answers every request word with exactly one result word.
// Release and unused-op requests go from the decode step straight to the
// result word, existing-slot requests pass through the offset calculation,
// and permanent allocation through the append step and then the calculation
// (a full table skips the calculation). Allocate-with-reuse reads the class
// table one entry per cycle through the single read port; a match goes on to
// the calculation, no match to the append step. The next request word is
// taken in the cycle after the result turns valid at the earliest. Table
// entries beyond the class fill count are never read, so there is no
// clearing pass after reset. The finished result sits in an output
// register; the block takes no new request word until its previous result
// has left the sequencer.
module spill_slot_allocator_top #(
  parameter int SLOTS      = ssa_pkg::DEFAULT_SLOTS,
  parameter int SLOT_BYTES = ssa_pkg::DEFAULT_SLOT_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire ssa_pkg::req_t              req,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output ssa_pkg::rsp_t                   rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssa_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssa_pkg::DATA_W-1:0] pwdata,
  output logic [ssa_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  `include "assert_macros.svh"

  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int MADDR_W   = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** MADDR_W;
  localparam int SLOT_W    = (IDX_W > 6) ? IDX_W : 6;
  localparam int CW        = ssa_pkg::CALC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPEND,
    S_CALC,
    S_DONE
  } state_t;

  state_t state;

  logic [ssa_pkg::BASE_W-1:0] gpr_base;
  logic [ssa_pkg::BASE_W-1:0] xmm_base;
  logic [ssa_pkg::BASE_W-1:0] placeholder_limit;

  ssa_pkg::req_t item;
  ssa_pkg::rsp_t res;
  logic [CNT_W-1:0]  cnt_q [2];
  logic [CNT_W-1:0]  ptr;
  logic [IDX_W-1:0]  chk_idx;
  logic              chk_valid;
  logic [SLOT_W-1:0] slot_q;
  logic              fresh_q;

  logic [32:0]       stop_mem [MEM_DEPTH];
  logic              use_mem  [MEM_DEPTH];
  logic [31:0]       rd_stop;
  logic              rd_forever;
  logic              rd_use;

  logic [MADDR_W-1:0] rd_addr;
  logic [MADDR_W-1:0] wr_addr;
  logic               stop_we;
  logic               use_we;
  logic [31:0]        wr_stop;
  logic               wr_forever;
  logic               wr_use;

  logic [CNT_W-1:0] cnt_cur;
  logic             full;
  logic             rel_ok;
  logic             match;
  logic             hit;
  logic             issue;

  logic [CW-1:0]        base_x;
  logic [CW-1:0]        rend_x;
  logic signed [CW-1:0] lim;
  logic                 in_range;
  logic [CW-1:0]        sum;
  logic [31:0]          prod;
  logic [31:0]          off;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      ssa_pkg::REG_GPR_BASE: prdata = {16'd0, gpr_base};
      ssa_pkg::REG_XMM_BASE: prdata = {16'd0, xmm_base};
      ssa_pkg::REG_LIMIT:    prdata = {16'd0, placeholder_limit};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_base          <= ssa_pkg::GPR_BASE_RESET;
      xmm_base          <= ssa_pkg::XMM_BASE_RESET;
      placeholder_limit <= ssa_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ssa_pkg::REG_GPR_BASE: gpr_base          <= pwdata[15:0];
        ssa_pkg::REG_XMM_BASE: xmm_base          <= pwdata[15:0];
        ssa_pkg::REG_LIMIT:    placeholder_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // table control
  assign cnt_cur = cnt_q[item.reg_class];
  assign full    = (cnt_cur == CNT_W'(SLOTS));
  assign rel_ok  = (32'(item.slot_index) < 32'(cnt_cur));
  assign issue   = (ptr < cnt_cur);
  assign match   = !rd_use || (!rd_forever && (rd_stop <= item.interval_start));
  assign hit     = (state == S_SCAN) && chk_valid && match;
  assign rd_addr = {item.reg_class, ptr[IDX_W-1:0]};

  always_comb begin
    stop_we    = 1'b0;
    use_we     = 1'b0;
    wr_addr    = {item.reg_class, cnt_cur[IDX_W-1:0]};
    wr_stop    = item.interval_end;
    wr_forever = 1'b0;
    wr_use     = 1'b1;
    case (state)
      S_DECODE: begin
        if (item.op == ssa_pkg::OP_RELEASE && rel_ok) begin
          use_we  = 1'b1;
          wr_use  = 1'b0;
          wr_addr = {item.reg_class, IDX_W'(item.slot_index)};
        end
      end
      S_SCAN: begin
        if (hit) begin
          stop_we = 1'b1;
          use_we  = 1'b1;
          wr_addr = {item.reg_class, chk_idx};
        end
      end
      S_APPEND: begin
        if (!full) begin
          stop_we = 1'b1;
          use_we  = 1'b1;
          if (item.op == ssa_pkg::OP_PERMANENT) begin
            wr_stop    = '1;
            wr_forever = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stop_we) begin
      stop_mem[wr_addr] <= {wr_forever, wr_stop};
    end
    if (use_we) begin
      use_mem[wr_addr] <= wr_use;
    end
    {rd_forever, rd_stop} <= stop_mem[rd_addr];
    rd_use                <= use_mem[rd_addr];
  end

  // range check and frame displacement
  assign base_x   = item.reg_class ? CW'(xmm_base) : CW'(gpr_base);
  assign rend_x   = item.reg_class ? CW'(placeholder_limit) : CW'(xmm_base);
  assign lim      = $signed(rend_x - base_x - CW'(1));
  assign in_range = $signed(CW'(slot_q)) < lim;
  assign sum      = CW'(slot_q) + base_x + CW'(1);
  assign prod     = 32'(sum) * 32'(SLOT_BYTES);
  assign off      = 32'd0 - prod;

  assign req_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      chk_valid <= 1'b0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          fresh_q   <= 1'b0;
          ptr       <= '0;
          chk_valid <= 1'b0;
          if (item.op == ssa_pkg::OP_RELEASE) begin
            res   <= '{slot: item.slot_index, fresh: 1'b0, frame_offset: '0,
                       status: ssa_pkg::ST_OK};
            state <= S_DONE;
          end else if (item.op != ssa_pkg::OP_REUSE && item.op != ssa_pkg::OP_PERMANENT) begin
            res   <= '{slot: '0, fresh: 1'b0, frame_offset: '0, status: ssa_pkg::ST_OK};
            state <= S_DONE;
          end else if (item.has_slot) begin
            slot_q <= SLOT_W'(item.slot_index);
            state  <= S_CALC;
          end else if (item.op == ssa_pkg::OP_REUSE) begin
            state <= S_SCAN;
          end else begin
            state <= S_APPEND;
          end
        end
        S_SCAN: begin
          if (hit) begin
            slot_q    <= SLOT_W'(chk_idx);
            chk_valid <= 1'b0;
            state     <= S_CALC;
          end else if (issue) begin
            chk_valid <= 1'b1;
            chk_idx   <= ptr[IDX_W-1:0];
            ptr       <= ptr + CNT_W'(1);
          end else begin
            chk_valid <= 1'b0;
            state     <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (full) begin
            res   <= '{slot: '0, fresh: 1'b0, frame_offset: '0, status: ssa_pkg::ST_FULL};
            state <= S_DONE;
          end else begin
            cnt_q[item.reg_class] <= cnt_cur + CNT_W'(1);
            slot_q                <= SLOT_W'(cnt_cur);
            fresh_q               <= 1'b1;
            state                 <= S_CALC;
          end
        end
        S_CALC: begin
          res.slot  <= slot_q[5:0];
          res.fresh <= fresh_q;
          if (in_range) begin
            res.frame_offset <= $signed(off);
            res.status       <= item.has_slot ? ssa_pkg::ST_UNCHANGED : ssa_pkg::ST_OK;
          end else begin
            res.frame_offset <= '0;
            res.status       <= ssa_pkg::ST_RANGE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_gpr_count_max, clk, rst, cnt_q[0] <= CNT_W'(SLOTS), "gpr count overflow")
  `ASSERT_ALWAYS(a_count_step, clk, rst, $past(rst) || cnt_q[0] == $past(cnt_q[0]) || cnt_q[0] == $past(cnt_q[0]) + CNT_W'(1), "gpr count jumped")
  `ASSERT_IMPLY(a_full_result, clk, rst, rsp_valid && rsp.status == ssa_pkg::ST_FULL, !rsp.fresh && rsp.frame_offset == 0, "full result carries a slot")

endmodule

`default_nettype wire

// File: sim/spill_slot_allocator_top_test.sv
// Self-checking testbench of the spill slot allocator: directed table, then random words
`timescale 1ns / 1ps

module spill_slot_allocator_top_test;

  localparam int SLOTS      = ssa_pkg::DEFAULT_SLOTS;
  localparam int SLOT_BYTES = ssa_pkg::DEFAULT_SLOT_BYTES;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam bit PRED  = 1'b0;
  localparam bit KNOWN = 1'b1;

  localparam int RANDOM_CHUNKS   = 6;
  localparam int WORDS_PER_CHUNK = 242;
  localparam int LONG_HOLD       = 400;

  typedef struct {
    ssa_pkg::req_t word;
    bit            typed;
    ssa_pkg::rsp_t want;
  } plan_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  ssa_pkg::req_t req       = '0;
  logic          rsp_ready = 1'b0;
  logic          psel      = 1'b0;
  logic          penable   = 1'b0;
  logic          pwrite    = 1'b0;
  logic [3:0]    paddr     = '0;
  logic [31:0]   pwdata    = '0;
  logic          req_ready;
  logic          rsp_valid;
  ssa_pkg::rsp_t rsp;
  logic [31:0]   prdata;
  logic          pready;

  logic [ssa_pkg::BASE_W-1:0] cfg_gpr_base = ssa_pkg::GPR_BASE_RESET;
  logic [ssa_pkg::BASE_W-1:0] cfg_xmm_base = ssa_pkg::XMM_BASE_RESET;
  logic [ssa_pkg::BASE_W-1:0] cfg_limit    = ssa_pkg::LIMIT_RESET;

  bit [31:0] tbl_end     [2][SLOTS];
  bit        tbl_busy    [2][SLOTS];
  bit        tbl_forever [2][SLOTS];
  int        tbl_fill    [2];

  bit [31:0] stamp_now [2];

  ssa_pkg::rsp_t due_q [$];
  plan_row_t     plan  [$];
  ssa_pkg::rsp_t oldest;

  int err_cnt   = 0;
  int send_idle = 36;
  int recv_idle = 50;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  spill_slot_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit in_range(input bit c, input int s, output logic signed [31:0] off);
    int base;
    int rend;
    base = c ? {16'h0, cfg_xmm_base} : {16'h0, cfg_gpr_base};
    rend = c ? {16'h0, cfg_limit} : {16'h0, cfg_xmm_base};
    if (s >= rend - base - 1) begin
      off = '0;
      return 1'b0;
    end
    off = -(s + base + 1) * SLOT_BYTES;
    return 1'b1;
  endfunction

  function automatic ssa_pkg::rsp_t slot_predict(input ssa_pkg::req_t w);
    ssa_pkg::rsp_t      r;
    bit                 c;
    int                 fill;
    int                 pick;
    bit                 hit;
    bit                 ok;
    logic signed [31:0] off;
    r    = '0;
    c    = w.reg_class;
    fill = tbl_fill[c];
    pick = 0;
    hit  = 1'b0;
    if (w.op == OP_UNUSED) return r;
    if (w.op == ssa_pkg::OP_RELEASE) begin
      if (w.slot_index < fill) tbl_busy[c][w.slot_index] = 1'b0;
      r.slot = w.slot_index;
      return r;
    end
    if (w.has_slot) begin
      ok             = in_range(c, w.slot_index, off);
      r.slot         = w.slot_index;
      r.frame_offset = off;
      r.status       = ok ? ssa_pkg::ST_UNCHANGED : ssa_pkg::ST_RANGE;
      return r;
    end
    if (w.op == ssa_pkg::OP_REUSE) begin
      for (int i = 0; i < fill; i++) begin
        if (!hit && (!tbl_busy[c][i] ||
                     (!tbl_forever[c][i] && tbl_end[c][i] <= w.interval_start))) begin
          hit  = 1'b1;
          pick = i;
        end
      end
    end
    if (hit) begin
      tbl_end[c][pick]     = w.interval_end;
      tbl_busy[c][pick]    = 1'b1;
      tbl_forever[c][pick] = 1'b0;
    end else begin
      if (fill >= SLOTS) begin
        r.status = ssa_pkg::ST_FULL;
        return r;
      end
      pick              = fill;
      r.fresh           = 1'b1;
      tbl_busy[c][pick] = 1'b1;
      if (w.op == ssa_pkg::OP_PERMANENT) begin
        tbl_end[c][pick]     = 32'hFFFF_FFFF;
        tbl_forever[c][pick] = 1'b1;
      end else begin
        tbl_end[c][pick]     = w.interval_end;
        tbl_forever[c][pick] = 1'b0;
      end
      tbl_fill[c] = fill + 1;
    end
    ok             = in_range(c, pick, off);
    r.slot         = pick[5:0];
    r.frame_offset = off;
    r.status       = ok ? ssa_pkg::ST_OK : ssa_pkg::ST_RANGE;
    return r;
  endfunction

  function automatic ssa_pkg::req_t random_word();
    ssa_pkg::req_t w;
    int unsigned   roll;
    bit            c;
    w.op             = 2'($urandom_range(0, 3));
    w.reg_class      = 1'($urandom_range(0, 1));
    w.has_slot       = 1'($urandom_range(0, 1));
    w.slot_index     = 6'($urandom_range(0, 63));
    w.interval_start = $urandom;
    w.interval_end   = $urandom;
    c    = w.reg_class;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return w;
    end else if (roll < 55) begin
      w.op             = ssa_pkg::OP_REUSE;
      w.has_slot       = 1'b0;
      w.interval_start = stamp_now[c] + $urandom_range(0, 8);
      w.interval_end   = w.interval_start + $urandom_range(1, 200);
      stamp_now[c]     = stamp_now[c] + $urandom_range(0, 6);
    end else if (roll < 65) begin
      w.op       = ssa_pkg::OP_PERMANENT;
      w.has_slot = 1'b0;
    end else if (roll < 88) begin
      w.op = ssa_pkg::OP_RELEASE;
      if (tbl_fill[c] != 0) w.slot_index = 6'($urandom_range(0, tbl_fill[c] - 1));
    end else if (roll < 98) begin
      w.op       = $urandom_range(0, 1) ? ssa_pkg::OP_PERMANENT : ssa_pkg::OP_REUSE;
      w.has_slot = 1'b1;
    end else begin
      w.op = OP_UNUSED;
    end
    return w;
  endfunction

  function automatic void plan_add(input logic [1:0] op, input bit c, input bit has,
                                   input logic [5:0] idx, input logic [31:0] s,
                                   input logic [31:0] e, input bit typed,
                                   input logic [5:0] slot, input bit fresh,
                                   input logic signed [31:0] off, input logic [1:0] st);
    plan_row_t row;
    row.word.op             = op;
    row.word.reg_class      = c;
    row.word.has_slot       = has;
    row.word.slot_index     = idx;
    row.word.interval_start = s;
    row.word.interval_end   = e;
    row.typed               = typed;
    row.want.slot           = slot;
    row.want.fresh          = fresh;
    row.want.frame_offset   = off;
    row.want.status         = st;
    plan = {plan, row};
  endfunction

  task automatic offer(input ssa_pkg::req_t w, input bit typed, input ssa_pkg::rsp_t want);
    ssa_pkg::rsp_t got;
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    got   = slot_predict(w);
    due_q = {due_q, typed ? want : got};
  endtask

  task automatic settle(input int extra);
    req_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [ssa_pkg::BASE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ssa_pkg::REG_GPR_BASE) cfg_gpr_base = val;
    else if (idx == ssa_pkg::REG_XMM_BASE) cfg_xmm_base = val;
    else if (idx == ssa_pkg::REG_LIMIT) cfg_limit = val;
  endtask

  task automatic apply_setting(input int k);
    case (k)
      0: begin
        reg_write(ssa_pkg::REG_GPR_BASE, 16'd0);
        reg_write(ssa_pkg::REG_XMM_BASE, 16'hFFFF);
        reg_write(ssa_pkg::REG_LIMIT, 16'hFFFF);
      end
      1: begin
        reg_write(ssa_pkg::REG_GPR_BASE, 16'hFFFF);
        reg_write(ssa_pkg::REG_XMM_BASE, 16'd0);
        reg_write(ssa_pkg::REG_LIMIT, 16'd0);
      end
      2: begin
        reg_write(ssa_pkg::REG_GPR_BASE, 16'd100);
        reg_write(ssa_pkg::REG_XMM_BASE, 16'd140);
        reg_write(ssa_pkg::REG_LIMIT, 16'd180);
      end
      3: begin
        reg_write(ssa_pkg::REG_GPR_BASE, 16'd0);
        reg_write(ssa_pkg::REG_XMM_BASE, 16'd32);
        reg_write(ssa_pkg::REG_LIMIT, 16'd96);
      end
      4: begin
        reg_write(ssa_pkg::REG_GPR_BASE, 16'd1000);
        reg_write(ssa_pkg::REG_XMM_BASE, 16'd1064);
        reg_write(ssa_pkg::REG_LIMIT, 16'd1129);
      end
      default: begin
        reg_write(ssa_pkg::REG_GPR_BASE, ssa_pkg::GPR_BASE_RESET);
        reg_write(ssa_pkg::REG_XMM_BASE, ssa_pkg::XMM_BASE_RESET);
        reg_write(ssa_pkg::REG_LIMIT, ssa_pkg::LIMIT_RESET);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result word: slot=%0d fresh=%0d offset=%0d status=%0d",
                     rsp.slot, rsp.fresh, rsp.frame_offset, rsp.status);
        end else begin
          oldest = due_q.pop_front();
          if (rsp.slot !== oldest.slot || rsp.fresh !== oldest.fresh ||
              rsp.frame_offset !== oldest.frame_offset || rsp.status !== oldest.status) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("result mismatch: want slot=%0d fresh=%0d offset=%0d status=%0d, %s",
                       oldest.slot, oldest.fresh, oldest.frame_offset, oldest.status,
                       $sformatf("got slot=%0d fresh=%0d offset=%0d status=%0d",
                                 rsp.slot, rsp.fresh, rsp.frame_offset, rsp.status));
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    plan_add(OP_UNUSED, 1, 1, 63, '1, '1, KNOWN, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_RELEASE, 0, 0, 0, 0, 0, KNOWN, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_RELEASE, 1, 1, 63, '1, 0, KNOWN, 63, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 0, 0, 0, 0, 10, KNOWN, 0, 1, -2056, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 0, 0, 0, 5, 20, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 0, 0, 0, 10, 30, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_PERMANENT, 0, 0, 0, 0, 0, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 0, 0, 0, '1, '1, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_RELEASE, 0, 0, 2, 0, 0, KNOWN, 2, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 0, 0, 0, 0, 1, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_PERMANENT, 1, 0, 0, 0, 0, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 1, 0, 0, '1, 5, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 1, 0, 0, '1, 0, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_RELEASE, 1, 0, 0, 0, 0, KNOWN, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 1, 0, 0, 3, 4, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 0, 1, 63, 0, 0, KNOWN, 63, 0, -2560, ssa_pkg::ST_UNCHANGED);
    plan_add(ssa_pkg::OP_PERMANENT, 1, 1, 0, 0, 0, KNOWN, 0, 0, -131080, ssa_pkg::ST_UNCHANGED);
    plan_add(ssa_pkg::OP_RELEASE, 0, 1, 63, 0, 0, KNOWN, 63, 0, 0, ssa_pkg::ST_OK);
    plan_add(OP_UNUSED, 0, 0, 0, 0, 0, KNOWN, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_PERMANENT, 0, 0, 0, '1, '1, PRED, 0, 0, 0, ssa_pkg::ST_OK);
    plan_add(ssa_pkg::OP_REUSE, 1, 1, 63, 0, 0, KNOWN, 63, 0, -131584, ssa_pkg::ST_UNCHANGED);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) offer(plan[i].word, plan[i].typed, plan[i].want);

    for (int k = 0; k < RANDOM_CHUNKS; k++) begin
      settle(8);
      apply_setting(k);
      send_idle = (k < 2) ? 36 : (k < 4) ? 50 : 0;
      recv_idle = (k < 2) ? 50 : (k < 4) ? 36 : 0;
      if ($urandom_range(0, 1)) stamp_now[0] = $urandom;
      if ($urandom_range(0, 1)) stamp_now[1] = $urandom;
      for (int n = 0; n < WORDS_PER_CHUNK; n++) begin
        if (k == 1 && n == 40) hold_asks++;
        offer(random_word(), PRED, '0);
      end
    end

    settle(80);
    if (err_cnt == 0 && due_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
